// File: hw/rtl/srec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_pkg: shared types, constants and control store of the S-record encoder
// Holds the item structs, record type digits, step numbers and the
// microprogram that sequences one input item into record bytes.
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int DEF_MAX_DATA_BYTES = 27;
  localparam int STEP_W             = 5;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE_BYTES = 2'd2;

  localparam logic [31:0] START_ADDRESS_RST = 32'd0;
  localparam logic [4:0]  LINE_BYTES_RST    = 5'd16;

  // record type digits
  localparam logic [3:0] REC_HEADER = 4'd0;
  localparam logic [3:0] REC_DATA   = 4'd3;
  localparam logic [3:0] REC_COUNT  = 4'd5;
  localparam logic [3:0] REC_END    = 4'd7;

  // fixed record bytes
  localparam logic [7:0] SHORT_COUNT   = 8'h03;
  localparam logic [7:0] END_COUNT     = 8'h05;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] DATA_OVERHEAD = 8'd5;

  // address byte selectors, most significant first
  localparam logic [7:0] ADDR_B3 = 8'd3;
  localparam logic [7:0] ADDR_B2 = 8'd2;
  localparam logic [7:0] ADDR_B1 = 8'd1;
  localparam logic [7:0] ADDR_B0 = 8'd0;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT      = 5'd0;
  localparam step_t ST_HDR_INIT  = 5'd1;
  localparam step_t ST_HDR_STORE = 5'd2;
  localparam step_t ST_S0_COUNT  = 5'd3;
  localparam step_t ST_S0_ADDR1  = 5'd4;
  localparam step_t ST_S0_ADDR0  = 5'd5;
  localparam step_t ST_S0_CSUM   = 5'd6;
  localparam step_t ST_STORE     = 5'd7;
  localparam step_t ST_S3_COUNT  = 5'd8;
  localparam step_t ST_S3_ADDR3  = 5'd9;
  localparam step_t ST_S3_ADDR2  = 5'd10;
  localparam step_t ST_S3_ADDR1  = 5'd11;
  localparam step_t ST_S3_ADDR0  = 5'd12;
  localparam step_t ST_S3_DATA   = 5'd13;
  localparam step_t ST_S3_CSUM   = 5'd14;
  localparam step_t ST_S5_COUNT  = 5'd15;
  localparam step_t ST_S5_HI     = 5'd16;
  localparam step_t ST_S5_LO     = 5'd17;
  localparam step_t ST_S5_CSUM   = 5'd18;
  localparam step_t ST_S7_COUNT  = 5'd19;
  localparam step_t ST_S7_ADDR3  = 5'd20;
  localparam step_t ST_S7_ADDR2  = 5'd21;
  localparam step_t ST_S7_ADDR1  = 5'd22;
  localparam step_t ST_S7_ADDR0  = 5'd23;
  localparam step_t ST_S7_CSUM   = 5'd24;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_HDR_INIT,
    OP_STORE,
    OP_CLR_IDX,
    OP_FLUSH_UPD,
    OP_RUN_END
  } op_t;

  typedef enum logic [2:0] {
    SRC_IMM,
    SRC_COUNT,
    SRC_ADDR,
    SRC_DATA,
    SRC_CSUM,
    SRC_TALLY_HI,
    SRC_TALLY_LO
  } src_t;

  typedef enum logic [1:0] {
    RL_NEVER,
    RL_ALWAYS,
    RL_NO_FLUSH,
    RL_NO_LAST
  } rl_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_HDR_DONE,
    JC_FLUSH,
    JC_LAST,
    JC_MORE
  } cond_t;

  typedef struct packed {
    op_t        op;
    logic       emit;
    src_t       src;
    logic [7:0] imm;
    logic [3:0] rtype;
    logic       start;
    logic       stop;
    rl_t        rl;
    cond_t      cond;
    step_t      jmp;
    step_t      nxt;
  } ctl_t;

  typedef struct packed {
    logic hdr_done;
    logic flush;
    logic last;
    logic more;
    logic done;
  } stat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [3:0] rec_type;
    logic [7:0] value;
    logic [6:0] hi_char;
    logic [6:0] lo_char;
    logic       rec_start;
    logic       rec_end;
    logic       run_last;
  } res_t;

  function automatic logic [6:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? (7'd48 + 7'(nib)) : (7'd55 + 7'(nib));
  endfunction

  function automatic ctl_t ctl_op(op_t op, cond_t c, step_t j, step_t n);
    ctl_t w;
    w       = '0;
    w.op    = op;
    w.src   = SRC_IMM;
    w.rl    = RL_NEVER;
    w.cond  = c;
    w.jmp   = j;
    w.nxt   = n;
    return w;
  endfunction

  function automatic ctl_t ctl_emit(src_t s, logic [7:0] imm, logic [3:0] t,
                                    logic st, logic en, rl_t rl, op_t op,
                                    cond_t c, step_t j, step_t n);
    ctl_t w;
    w       = '0;
    w.op    = op;
    w.emit  = 1'b1;
    w.src   = s;
    w.imm   = imm;
    w.rtype = t;
    w.start = st;
    w.stop  = en;
    w.rl    = rl;
    w.cond  = c;
    w.jmp   = j;
    w.nxt   = n;
    return w;
  endfunction

  // control store: one word per step
  function automatic ctl_t ucode(step_t step);
    ctl_t w;
    unique case (step)
      ST_WAIT:      w = ctl_op(OP_ACCEPT, JC_HDR_DONE, ST_STORE, ST_HDR_INIT);
      ST_HDR_INIT:  w = ctl_op(OP_HDR_INIT, JC_NONE, ST_HDR_STORE, ST_HDR_STORE);
      ST_HDR_STORE: w = ctl_op(OP_STORE, JC_NONE, ST_S0_COUNT, ST_S0_COUNT);
      ST_S0_COUNT:  w = ctl_emit(SRC_IMM, SHORT_COUNT, REC_HEADER, 1'b1, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S0_ADDR1, ST_S0_ADDR1);
      ST_S0_ADDR1:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_HEADER, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S0_ADDR0, ST_S0_ADDR0);
      ST_S0_ADDR0:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_HEADER, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S0_CSUM, ST_S0_CSUM);
      ST_S0_CSUM:   w = ctl_emit(SRC_CSUM, ZERO_BYTE, REC_HEADER, 1'b0, 1'b1, RL_NO_FLUSH,
                                 OP_NONE, JC_FLUSH, ST_S3_COUNT, ST_WAIT);
      ST_STORE:     w = ctl_op(OP_STORE, JC_FLUSH, ST_S3_COUNT, ST_WAIT);
      ST_S3_COUNT:  w = ctl_emit(SRC_COUNT, ZERO_BYTE, REC_DATA, 1'b1, 1'b0, RL_NEVER,
                                 OP_CLR_IDX, JC_NONE, ST_S3_ADDR3, ST_S3_ADDR3);
      ST_S3_ADDR3:  w = ctl_emit(SRC_ADDR, ADDR_B3, REC_DATA, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S3_ADDR2, ST_S3_ADDR2);
      ST_S3_ADDR2:  w = ctl_emit(SRC_ADDR, ADDR_B2, REC_DATA, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S3_ADDR1, ST_S3_ADDR1);
      ST_S3_ADDR1:  w = ctl_emit(SRC_ADDR, ADDR_B1, REC_DATA, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S3_ADDR0, ST_S3_ADDR0);
      ST_S3_ADDR0:  w = ctl_emit(SRC_ADDR, ADDR_B0, REC_DATA, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S3_DATA, ST_S3_DATA);
      ST_S3_DATA:   w = ctl_emit(SRC_DATA, ZERO_BYTE, REC_DATA, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_MORE, ST_S3_DATA, ST_S3_CSUM);
      ST_S3_CSUM:   w = ctl_emit(SRC_CSUM, ZERO_BYTE, REC_DATA, 1'b0, 1'b1, RL_NO_LAST,
                                 OP_FLUSH_UPD, JC_LAST, ST_S5_COUNT, ST_WAIT);
      ST_S5_COUNT:  w = ctl_emit(SRC_IMM, SHORT_COUNT, REC_COUNT, 1'b1, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S5_HI, ST_S5_HI);
      ST_S5_HI:     w = ctl_emit(SRC_TALLY_HI, ZERO_BYTE, REC_COUNT, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S5_LO, ST_S5_LO);
      ST_S5_LO:     w = ctl_emit(SRC_TALLY_LO, ZERO_BYTE, REC_COUNT, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S5_CSUM, ST_S5_CSUM);
      ST_S5_CSUM:   w = ctl_emit(SRC_CSUM, ZERO_BYTE, REC_COUNT, 1'b0, 1'b1, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_COUNT, ST_S7_COUNT);
      ST_S7_COUNT:  w = ctl_emit(SRC_IMM, END_COUNT, REC_END, 1'b1, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_ADDR3, ST_S7_ADDR3);
      ST_S7_ADDR3:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_END, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_ADDR2, ST_S7_ADDR2);
      ST_S7_ADDR2:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_END, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_ADDR1, ST_S7_ADDR1);
      ST_S7_ADDR1:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_END, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_ADDR0, ST_S7_ADDR0);
      ST_S7_ADDR0:  w = ctl_emit(SRC_IMM, ZERO_BYTE, REC_END, 1'b0, 1'b0, RL_NEVER,
                                 OP_NONE, JC_NONE, ST_S7_CSUM, ST_S7_CSUM);
      ST_S7_CSUM:   w = ctl_emit(SRC_CSUM, ZERO_BYTE, REC_END, 1'b0, 1'b1, RL_ALWAYS,
                                 OP_RUN_END, JC_NONE, ST_WAIT, ST_WAIT);
      default:      w = ctl_op(OP_NONE, JC_NONE, ST_WAIT, ST_WAIT);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/srec_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_seq: microprogram sequencer
// Step counter over the control store; each step holds until its work completes,
// then falls through to its next word or takes its jump when the selected condition holds.
// ----------------------------------------------------------------------------
module srec_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire srec_pkg::stat_t stat,
  output srec_pkg::ctl_t      ctl
);

  srec_pkg::step_t step;
  srec_pkg::step_t step_next;
  logic            cond_true;

  assign ctl = srec_pkg::ucode(step);

  always_comb begin
    unique case (ctl.cond)
      srec_pkg::JC_HDR_DONE: cond_true = stat.hdr_done;
      srec_pkg::JC_FLUSH:    cond_true = stat.flush;
      srec_pkg::JC_LAST:     cond_true = stat.last;
      srec_pkg::JC_MORE:     cond_true = stat.more;
      default:               cond_true = 1'b0;
    endcase
  end

  // hold the step until its work completes
  always_comb begin
    if (!stat.done) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = ctl.jmp;
    end else begin
      step_next = ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= srec_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/srec_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_dpath: encoder datapath
// Configuration registers, record state, line store, checksum accumulator
// and the output register; all but the configuration are driven by the current control word.
// ----------------------------------------------------------------------------
module srec_dpath #(
  parameter int MAX_DATA_BYTES = srec_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [srec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srec_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire srec_pkg::item_t                 in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output srec_pkg::res_t                       out_data,
  input  wire srec_pkg::ctl_t                  ctl,
  output srec_pkg::stat_t                      stat
);

  localparam int CW = $clog2(MAX_DATA_BYTES + 1);
  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic [31:0]   start_address;
  logic [4:0]    bytes_per_line;
  logic [4:0]    first_line_bytes;

  logic [7:0]    byte_r;
  logic          last_r;
  logic [CW-1:0] fill;
  logic [CW-1:0] target;
  logic [31:0]   record_address;
  logic [15:0]   record_tally;
  logic          header_done;
  logic          flush_r;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_idx_next;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    sum;

  logic [7:0]    line_store [MAX_DATA_BYTES];

  logic          can_load;
  logic          fire;
  logic          flush_now;
  logic [CW:0]   fill_inc;
  logic [CW:0]   rd_idx_inc;
  logic [CW-1:0] bpl_c;
  logic [CW-1:0] fl_c;
  logic [7:0]    value;
  logic          run_last;

  function automatic logic [CW-1:0] clamp_size(logic [4:0] v);
    if (v == 5'd0) begin
      return CW'(1);
    end else if (int'(v) > MAX_DATA_BYTES) begin
      return CW'(MAX_DATA_BYTES);
    end else begin
      return CW'(v);
    end
  endfunction

  assign bpl_c      = clamp_size(bytes_per_line);
  assign fl_c       = clamp_size(first_line_bytes);
  assign fill_inc   = {1'b0, fill} + (CW+1)'(1);
  assign rd_idx_inc = {1'b0, rd_idx} + (CW+1)'(1);
  assign flush_now  = (fill_inc >= {1'b0, target}) || last_r;

  assign in_ready = (ctl.op == srec_pkg::OP_ACCEPT);
  assign can_load = !out_valid || out_ready;
  assign fire     = ctl.emit && can_load;

  always_comb begin
    stat.hdr_done = header_done;
    stat.flush    = (ctl.op == srec_pkg::OP_STORE) ? flush_now : flush_r;
    stat.last     = last_r;
    stat.more     = rd_idx_inc < {1'b0, fill};
    if (ctl.emit) begin
      stat.done = can_load;
    end else if (ctl.op == srec_pkg::OP_ACCEPT) begin
      stat.done = in_valid;
    end else begin
      stat.done = 1'b1;
    end
  end

  always_comb begin
    case (ctl.src)
      srec_pkg::SRC_COUNT:    value = 8'(fill) + srec_pkg::DATA_OVERHEAD;
      srec_pkg::SRC_ADDR: begin
        case (ctl.imm[1:0])
          2'd3:    value = record_address[31:24];
          2'd2:    value = record_address[23:16];
          2'd1:    value = record_address[15:8];
          default: value = record_address[7:0];
        endcase
      end
      srec_pkg::SRC_DATA:     value = rd_data;
      srec_pkg::SRC_CSUM:     value = ~sum;
      srec_pkg::SRC_TALLY_HI: value = record_tally[15:8];
      srec_pkg::SRC_TALLY_LO: value = record_tally[7:0];
      default:                value = ctl.imm;
    endcase
  end

  always_comb begin
    case (ctl.rl)
      srec_pkg::RL_ALWAYS:   run_last = 1'b1;
      srec_pkg::RL_NO_FLUSH: run_last = !flush_r;
      srec_pkg::RL_NO_LAST:  run_last = !last_r;
      default:               run_last = 1'b0;
    endcase
  end

  // read address runs one step ahead so the data byte is ready each cycle
  always_comb begin
    if (ctl.op == srec_pkg::OP_CLR_IDX) begin
      rd_idx_next = '0;
    end else if (fire && ctl.src == srec_pkg::SRC_DATA) begin
      rd_idx_next = rd_idx_inc[CW-1:0];
    end else begin
      rd_idx_next = rd_idx;
    end
    rd_addr = (rd_idx_next < CW'(MAX_DATA_BYTES)) ? IW'(rd_idx_next) : '0;
  end

  always_ff @(posedge clk) begin
    rd_data <= line_store[rd_addr];
    if (ctl.op == srec_pkg::OP_STORE && fill < CW'(MAX_DATA_BYTES)) begin
      line_store[IW'(fill)] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address    <= srec_pkg::START_ADDRESS_RST;
      bytes_per_line   <= srec_pkg::LINE_BYTES_RST;
      first_line_bytes <= srec_pkg::LINE_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srec_pkg::CFG_START_ADDRESS:    start_address    <= cfg_data;
        srec_pkg::CFG_BYTES_PER_LINE:   bytes_per_line   <= cfg_data[4:0];
        srec_pkg::CFG_FIRST_LINE_BYTES: first_line_bytes <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data.data_byte;
    end
    if (fire) begin
      sum                <= ctl.start ? value : sum + value;
      out_data.rec_type  <= ctl.rtype;
      out_data.value     <= value;
      out_data.hi_char   <= srec_pkg::hex_char(value[7:4]);
      out_data.lo_char   <= srec_pkg::hex_char(value[3:0]);
      out_data.rec_start <= ctl.start;
      out_data.rec_end   <= ctl.stop;
      out_data.run_last  <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_r         <= 1'b0;
      fill           <= '0;
      target         <= '0;
      record_address <= '0;
      record_tally   <= '0;
      header_done    <= 1'b0;
      flush_r        <= 1'b0;
      rd_idx         <= '0;
      out_valid      <= 1'b0;
    end else begin
      rd_idx <= rd_idx_next;
      if (in_valid && in_ready) begin
        last_r <= in_data.is_last;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.op)
        srec_pkg::OP_HDR_INIT: begin
          header_done    <= 1'b1;
          record_address <= start_address;
          record_tally   <= '0;
          fill           <= '0;
          target         <= (fl_c < bpl_c) ? fl_c : bpl_c;
        end
        srec_pkg::OP_STORE: begin
          flush_r <= flush_now;
          if (fill < CW'(MAX_DATA_BYTES)) begin
            fill <= fill_inc[CW-1:0];
          end
        end
        srec_pkg::OP_FLUSH_UPD: begin
          if (fire) begin
            record_tally   <= record_tally + 16'd1;
            record_address <= record_address + 32'(fill);
            fill           <= '0;
            target         <= bpl_c;
          end
        end
        srec_pkg::OP_RUN_END: begin
          if (fire) begin
            header_done <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/srecord_s3_stream_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_s3_stream_encoder_core: S0/S3/S5/S7 record stream encoder
// Turns a marked run of data bytes into the record bytes of an S-record file.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one data byte per item, is_last
//     marks the end of a run. The first item of a run opens with an S0 record.
//   out channel (out_valid/out_ready/out_data): one record byte per item with
//     its hex digits, record type and record start/end marks; run_last flags
//     the final byte produced by an input item.
//   cfg port (cfg_we/cfg_index/cfg_data): start address, bytes per line and
//     first line size; write only while the block is idle.
// Timing: a microprogram steps once per cycle unless a step waits on a channel,
//   and emits at most one record byte per cycle through a single output
//   register. An item that closes no record passes the wait and store steps;
//   a run's first item adds init and S0, a closed S3 record its own steps and
//   the trailer S5 and S7. Results appear in the cycle after their step.
// Reset clears the run state and restores the configuration defaults. When
//   the receiver stalls, the current step holds and the output byte waits;
//   the next input is taken once the sequencer is back at its wait step.
// ----------------------------------------------------------------------------
module srecord_s3_stream_encoder_core #(
  parameter int MAX_DATA_BYTES = srec_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [srec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srec_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire srec_pkg::item_t                 in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output srec_pkg::res_t                       out_data
);

  srec_pkg::ctl_t  ctl;
  srec_pkg::stat_t stat;

  srec_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  srec_dpath #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// File: hw/rtl/srec_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_checker: port-level checks for the S-record encoder
// Watches the top level's channels and flags stall, record framing and input slips.
// ----------------------------------------------------------------------------
module srec_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire srec_pkg::res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // count byte and checksum byte never coincide
  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.rec_start && out_data.rec_end))
    else $error("record start and end on the same byte");

  // the last result of an input always closes a record
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.run_last |-> out_data.rec_end)
    else $error("run_last outside a checksum byte");

  // an accepted item closes the input in the cycle after it
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind srecord_s3_stream_encoder_core srec_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
